// ----- sv/b64sd_pkg.sv -----
// Shared types, constants and the character-value function for the base64 stream decoder.
// No dependencies; imported by every module of the block.
package b64sd_pkg;

  localparam int CountWidthDef = 16;
  localparam int MaxBytesW     = 16;
  localparam logic [MaxBytesW-1:0] MaxBytesReset = 16'hFFFF;
  localparam int QueueDepth    = 4;

  localparam logic [7:0] PadChar = 8'h3D;

  // One decoded group, or the error marker of a rejected string.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nb;
    logic        last;
    logic        err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Returns {legal, sextet}.
  function automatic logic [6:0] char_value(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'h2B || c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F || c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- sv/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder: front end, command queue, back end.
// Depends on b64sd_pkg, b64sd_front, b64sd_queue and b64sd_back.
//
// channel  direction  handshake                 payload
// cfg      in         cfg_we_i                  cfg_wdata_i (max_output_bytes)
// in       in         in_valid_i / in_ready_o   text_char_i, final_char_i
// out      out        out_valid_o / out_ready_i data_byte_o, byte_valid_o,
//                                               end_of_run_o, error_flag_o
//
// One character per cycle is accepted while in_ready_o is high; a completed group
// is queued at the edge that accepts its last character, and its one to three
// results leave at one per cycle from the output register. The back end drains one
// result per cycle while out_ready_i is high, so four characters per group keep the
// four-entry queue from filling. in_ready_o drops only while the queue is full.
// Reset clears all stream state and sets the capacity register to 65535.
module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64sd_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [b64sd_pkg::MaxBytesW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      text_char_i,
  input  logic                            final_char_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      data_byte_o,
  output logic                            byte_valid_o,
  output logic                            end_of_run_o,
  output logic                            error_flag_o
);
  import b64sd_pkg::*;

  logic   push, pop;
  cmd_t   cmd, head;
  qstat_t qstat;

  b64sd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .text_char_i, .final_char_i,
    .qstat_i(qstat), .push_o(push), .cmd_o(cmd)
  );

  b64sd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd), .pop_i(pop),
    .head_o(head), .qstat_o(qstat)
  );

  b64sd_back u_back (
    .clk_i, .rst_ni, .head_i(head), .qstat_i(qstat), .pop_o(pop),
    .out_valid_o, .out_ready_i, .data_byte_o, .byte_valid_o,
    .end_of_run_o, .error_flag_o
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("push into full queue");
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_flag_o) |-> (end_of_run_o && !byte_valid_o && data_byte_o == 8'd0))
    else $error("malformed error result");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o != error_flag_o)) else $error("result kind unclear");
`endif

endmodule

// ----- sv/b64sd_front.sv -----
// Front end: accepts characters, tracks group and padding state, checks capacity.
// Pushes one command per valid completed group or per final character. Uses b64sd_pkg.
module b64sd_front #(
  parameter int COUNT_WIDTH = b64sd_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [b64sd_pkg::MaxBytesW-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       text_char_i,
  input  logic                             final_char_i,
  input  b64sd_pkg::qstat_t                qstat_i,
  output logic                             push_o,
  output b64sd_pkg::cmd_t                  cmd_o
);
  import b64sd_pkg::*;

  localparam int CntW = COUNT_WIDTH + 1;
  localparam int CmpW = ((CntW > MaxBytesW) ? CntW : MaxBytesW) + 1;

  logic [MaxBytesW-1:0] max_q;
  logic [17:0]          acc_q, acc_d;
  logic [1:0]           slot_q, slot_d;
  logic [1:0]           pad_q, pad_d;
  logic                 err_q, err_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic        accept, is_pad, bad_char, grp_bad, grp_ok, err_fin;
  logic [6:0]  cv;
  logic [5:0]  v;
  logic [1:0]  padn, nb;
  logic [CmpW-1:0] sum, lim_cnt, lim_reg, limit;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_pad  = (text_char_i == PadChar);
    cv      = char_value(text_char_i);
    v       = is_pad ? 6'd0 : cv[5:0];
    padn    = pad_q + {1'b0, is_pad};
    nb      = 2'd3 - padn;
    bad_char = is_pad ? (slot_q < 2'd2) : (!cv[6] || pad_q != 2'd0);
    sum     = CmpW'(cnt_q) + CmpW'(nb);
    lim_cnt = CmpW'({CntW{1'b1}});
    lim_reg = CmpW'(max_q);
    limit   = (lim_cnt < lim_reg) ? lim_cnt : lim_reg;

    acc_d   = acc_q;
    slot_d  = slot_q;
    pad_d   = pad_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    grp_bad = 1'b0;
    grp_ok  = 1'b0;

    if (!err_q) begin
      if (bad_char) begin
        err_d = 1'b1;
      end else if (slot_q != 2'd3) begin
        acc_d  = {acc_q[11:0], v};
        slot_d = slot_q + 2'd1;
        pad_d  = padn;
      end else begin
        grp_bad = (padn != 2'd0 && !final_char_i) || (sum > limit);
        grp_ok  = !grp_bad;
        if (grp_bad) err_d = 1'b1;
        else cnt_d = CntW'(sum);
        acc_d  = '0;
        slot_d = 2'd0;
        pad_d  = 2'd0;
      end
    end

    err_fin = err_d || (slot_d != 2'd0);

    cmd_o.bytes = {acc_q, v};
    cmd_o.nb    = nb;
    cmd_o.last  = final_char_i;
    cmd_o.err   = final_char_i && err_fin;
    push_o      = accept && (final_char_i || grp_ok);

    if (final_char_i) begin
      acc_d  = '0;
      slot_d = 2'd0;
      pad_d  = 2'd0;
      cnt_d  = '0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MaxBytesReset;
      acc_q  <= '0;
      slot_q <= '0;
      pad_q  <= '0;
      err_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (accept) begin
        acc_q  <= acc_d;
        slot_q <= slot_d;
        pad_q  <= pad_d;
        err_q  <= err_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule

// ----- sv/b64sd_queue.sv -----
// Short command queue between front and back end.
// Register-based FIFO of b64sd_pkg::cmd_t entries. Uses b64sd_pkg.
module b64sd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64sd_pkg::cmd_t   cmd_i,
  input  logic              pop_i,
  output b64sd_pkg::cmd_t   head_o,
  output b64sd_pkg::qstat_t qstat_o
);
  import b64sd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign head_o        = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= PtrW'(wr_q + 1'b1);
      if (pop_i)  rd_q <= PtrW'(rd_q + 1'b1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- sv/b64sd_back.sv -----
// Back end: expands each queued command into byte results or one error result.
// Holds the output register of the result channel. Uses b64sd_pkg.
module b64sd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64sd_pkg::cmd_t   head_i,
  input  b64sd_pkg::qstat_t qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        data_byte_o,
  output logic              byte_valid_o,
  output logic              end_of_run_o,
  output logic              error_flag_o
);
  import b64sd_pkg::*;

  logic       load, last_byte;
  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] data_q, data_d;
  logic       bv_q, bv_d, eor_q, eor_d, err_q, err_d;

  always_comb begin
    load      = (!vld_q || out_ready_i) && !qstat_i.empty;
    last_byte = (idx_q == head_i.nb - 2'd1);
    pop_o     = load && (head_i.err || last_byte);
    idx_d     = idx_q;
    vld_d     = vld_q && !out_ready_i;
    data_d    = data_q;
    bv_d      = bv_q;
    eor_d     = eor_q;
    err_d     = err_q;
    if (load) begin
      vld_d = 1'b1;
      if (head_i.err) begin
        data_d = 8'd0;
        bv_d   = 1'b0;
        eor_d  = 1'b1;
        err_d  = 1'b1;
        idx_d  = 2'd0;
      end else begin
        case (idx_q)
          2'd0:    data_d = head_i.bytes[23:16];
          2'd1:    data_d = head_i.bytes[15:8];
          default: data_d = head_i.bytes[7:0];
        endcase
        bv_d  = 1'b1;
        eor_d = head_i.last && last_byte;
        err_d = 1'b0;
        idx_d = last_byte ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    bv_q   <= bv_d;
    eor_q  <= eor_d;
    err_q  <= err_d;
  end

  assign out_valid_o  = vld_q;
  assign data_byte_o  = data_q;
  assign byte_valid_o = bv_q;
  assign end_of_run_o = eor_q;
  assign error_flag_o = err_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for base64_stream_decoder: directed table, then random strings.
// Depends on b64sd_pkg and the base64_stream_decoder RTL; predicts every result in place.
module tb;
  import b64sd_pkg::*;

  localparam int CntW = CountWidthDef;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } dec_result_t;

  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_REJECT, ROW_CAP} row_kind_e;

  typedef struct {
    logic [7:0]  ch;
    logic        fin;
    row_kind_e   kind;
    logic [15:0] cap;
  } row_t;

  localparam dec_result_t RejectRes = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam int NRows = 31;

  row_t script [NRows] = '{
    '{"A", 1'b0, ROW_QUIET, 16'd0}, '{"A", 1'b0, ROW_QUIET, 16'd0},
    '{"A", 1'b0, ROW_QUIET, 16'd0}, '{"A", 1'b1, ROW_MODEL, 16'd0},
    '{"/", 1'b0, ROW_QUIET, 16'd0}, '{"_", 1'b0, ROW_QUIET, 16'd0},
    '{"/", 1'b0, ROW_QUIET, 16'd0}, '{"/", 1'b1, ROW_MODEL, 16'd0},
    '{"Z", 1'b0, ROW_QUIET, 16'd0}, '{"g", 1'b0, ROW_QUIET, 16'd0},
    '{"=", 1'b0, ROW_QUIET, 16'd0}, '{"=", 1'b1, ROW_MODEL, 16'd0},
    '{"=", 1'b1, ROW_REJECT, 16'd0},
    '{8'h00, 1'b1, ROW_REJECT, 16'd0},
    '{8'hFF, 1'b1, ROW_REJECT, 16'd0},
    '{"A", 1'b0, ROW_QUIET, 16'd0}, '{"B", 1'b1, ROW_REJECT, 16'd0},
    '{"A", 1'b0, ROW_QUIET, 16'd0}, '{"B", 1'b0, ROW_QUIET, 16'd0},
    '{"=", 1'b0, ROW_QUIET, 16'd0}, '{"C", 1'b1, ROW_REJECT, 16'd0},
    '{"A", 1'b0, ROW_QUIET, 16'd0}, '{"B", 1'b0, ROW_QUIET, 16'd0},
    '{"=", 1'b0, ROW_QUIET, 16'd0}, '{"=", 1'b0, ROW_QUIET, 16'd0},
    '{"A", 1'b1, ROW_REJECT, 16'd0},
    '{8'h00, 1'b0, ROW_CAP, 16'd0},
    '{"Q", 1'b0, ROW_QUIET, 16'd0}, '{"U", 1'b0, ROW_QUIET, 16'd0},
    '{"J", 1'b0, ROW_QUIET, 16'd0}, '{"D", 1'b1, ROW_REJECT, 16'd0}
  };

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [MaxBytesW-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           text_char = 8'h00;
  logic                 final_char = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic [7:0]           data_byte_o;
  logic                 byte_valid_o;
  logic                 end_of_run_o;
  logic                 error_flag_o;

  // predictor state
  logic [17:0]          acc_bits;
  logic [1:0]           slot;
  logic [1:0]           pads;
  logic                 rejected;
  logic [CntW:0]        nbytes;
  logic [MaxBytesW-1:0] cap_reg;

  dec_result_t decoded_q [$];
  int          idle_pct = 33;
  int          stall_pct = 33;
  int          mismatches = 0;

  base64_stream_decoder #(.COUNT_WIDTH(CntW)) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .text_char_i  (text_char),
    .final_char_i (final_char),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .end_of_run_o (end_of_run_o),
    .error_flag_o (error_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] any_b64();
    return b64_alpha[$urandom_range(65)];
  endfunction

  // Drives one item, then predicts what it causes; a model row queues that, a reject row an error result.
  task automatic feed_char(input logic [7:0] ch, input logic fin, input row_kind_e kind);
    dec_result_t step_res [$];
    logic        bad;
    logic        legal;
    logic [5:0]  sx;
    logic [23:0] quad;
    int          nb;
    longint      lim;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    text_char  <= ch;
    final_char <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    bad = 1'b0;
    legal = 1'b1;
    sx = '0;
    if (!rejected) begin
      if (ch == PadChar) begin
        if (slot < 2) bad = 1'b1;
        else pads = pads + 2'd1;
      end else begin
        if (ch >= "A" && ch <= "Z") sx = 6'(ch - "A");
        else if (ch >= "a" && ch <= "z") sx = 6'(ch - "a" + 26);
        else if (ch >= "0" && ch <= "9") sx = 6'(ch - "0" + 52);
        else if (ch == "+" || ch == "-") sx = 6'd62;
        else if (ch == "/" || ch == "_") sx = 6'd63;
        else legal = 1'b0;
        if (!legal || pads != 0) bad = 1'b1;
      end
      if (!bad) begin
        if (slot < 3) begin
          acc_bits = {acc_bits[11:0], sx};
          slot = slot + 2'd1;
        end else begin
          quad = {acc_bits, sx};
          nb = 3 - int'(pads);
          lim = (longint'(1) << (CntW + 1)) - 1;
          if (longint'(cap_reg) < lim) lim = longint'(cap_reg);
          if (pads != 0 && !fin) begin
            bad = 1'b1;
          end else if (longint'(nbytes) + nb > lim) begin
            bad = 1'b1;
          end else begin
            for (int i = 0; i < nb; i++) begin
              step_res.push_back('{quad[23 - 8*i -: 8], 1'b1, 1'b0, 1'b0});
            end
            nbytes = nbytes + (CntW+1)'(nb);
          end
          acc_bits = '0;
          slot = '0;
          pads = '0;
        end
      end
      if (bad) rejected = 1'b1;
    end
    if (fin) begin
      if (!rejected && (slot != 0 || step_res.size() == 0)) rejected = 1'b1;
      if (rejected) begin
        step_res = {};
        step_res.push_back(RejectRes);
      end else begin
        step_res[step_res.size()-1].last = 1'b1;
      end
      acc_bits = '0;
      slot = '0;
      pads = '0;
      rejected = 1'b0;
      nbytes = '0;
    end else if (rejected) begin
      step_res = {};
    end

    case (kind)
      ROW_MODEL: foreach (step_res[i]) decoded_q.push_back(step_res[i]);
      ROW_REJECT: decoded_q.push_back(RejectRes);
      default: ;
    endcase
  endtask

  // Capacity changes only with the block drained.
  task automatic set_cap(input logic [MaxBytesW-1:0] value);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    cap_reg = value;
  endtask

  task automatic feed_string(output int nchars);
    logic [7:0] chars [$];
    int         ngrp;
    int         npad;
    int         len;
    int         r;
    if ($urandom_range(99) < 70) begin
      ngrp = $urandom_range(1, 3);
      npad = $urandom_range(2);
      for (int g = 0; g < ngrp; g++) begin
        for (int k = 0; k < 4; k++) begin
          if (g == ngrp - 1 && k >= 4 - npad) chars.push_back(PadChar);
          else chars.push_back(any_b64());
        end
      end
    end else begin
      len = $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 60) chars.push_back(any_b64());
        else if (r < 75) chars.push_back(PadChar);
        else chars.push_back(8'($urandom_range(255)));
      end
    end
    foreach (chars[i]) feed_char(chars[i], i == chars.size() - 1, ROW_MODEL);
    nchars = chars.size();
  endtask

  always @(posedge clk_i) begin : result_check
    dec_result_t got;
    dec_result_t want;
    got = '{data_byte_o, byte_valid_o, end_of_run_o, error_flag_o};
    if (rst_n && out_valid_o && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t unexpected result: byte=%02h valid=%b last=%b err=%b",
                 $time, got.data, got.valid, got.last, got.err);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected byte=%02h valid=%b last=%b err=%b, %s",
                   $time, want.data, want.valid, want.last, want.err, "see actual");
          $display("%0t           actual   byte=%02h valid=%b last=%b err=%b",
                   $time, got.data, got.valid, got.last, got.err);
          mismatches++;
        end
      end
    end
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int unsigned caps [6] = '{6, 65535, 2, 0, 12, 65535};
    int          sent;
    int          n;
    acc_bits = '0;
    slot     = '0;
    pads     = '0;
    rejected = 1'b0;
    nbytes   = '0;
    cap_reg  = MaxBytesReset;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CAP) set_cap(script[i].cap);
      else feed_char(script[i].ch, script[i].fin, script[i].kind);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_cap(caps[ph][15:0]);
      idle_pct  = (ph == 1) ? 0 : 33;
      stall_pct = (ph == 1) ? 0 : 33;
      sent = 0;
      while (sent < 34) begin
        feed_string(n);
        sent += n;
      end
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
